FILE: sv/lrutlb_pkg.sv
`timescale 1ns / 1ps

package lrutlb_pkg;

  // Default geometry
  localparam int ENTRIES_DEF    = 16;
  localparam int PAGE_BITS_DEF  = 8;
  localparam int FRAME_BITS_DEF = 8;

  // Result status codes
  typedef logic [1:0] status_t;
  localparam status_t ST_HIT   = 2'd0;
  localparam status_t ST_FILL  = 2'd1;
  localparam status_t ST_FAULT = 2'd2;

  // Per-cell update controls applied during an update
  typedef struct packed {
    logic shift;  // take the neighbor's (next newer) entry
    logic load;   // take the broadcast insert entry
  } cell_ctl_t;

endpackage

FILE: sv/lrutlb_cell.sv
`timescale 1ns / 1ps

// One slot of the LRU chain: holds a page/frame pair, compares it against the
// lookup page, and shifts in its newer neighbor or loads the insert data.
module lrutlb_cell #(
  parameter int PAGE_BITS  = lrutlb_pkg::PAGE_BITS_DEF,
  parameter int FRAME_BITS = lrutlb_pkg::FRAME_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cmp_en,
  input  logic [PAGE_BITS-1:0]  cmp_page,
  input  logic                  occupied,
  input  lrutlb_pkg::cell_ctl_t ctl,
  input  logic [PAGE_BITS-1:0]  nbr_page,
  input  logic [FRAME_BITS-1:0] nbr_frame,
  input  logic [PAGE_BITS-1:0]  ins_page,
  input  logic [FRAME_BITS-1:0] ins_frame,
  output logic [PAGE_BITS-1:0]  page,
  output logic [FRAME_BITS-1:0] frame,
  output logic                  match
);

  logic [PAGE_BITS-1:0]  page_r,  page_nxt;
  logic [FRAME_BITS-1:0] frame_r, frame_nxt;
  logic                  match_r, match_nxt;

  // Entry update: load wins, else shift from the newer neighbor, else hold
  always_comb begin
    page_nxt  = page_r;
    frame_nxt = frame_r;
    if (ctl.load) begin
      page_nxt  = ins_page;
      frame_nxt = ins_frame;
    end else if (ctl.shift) begin
      page_nxt  = nbr_page;
      frame_nxt = nbr_frame;
    end
  end

  // Compare result captured on lookup transfer
  always_comb begin
    match_nxt = match_r;
    if (cmp_en) begin
      match_nxt = occupied && (page_r == cmp_page);
    end
  end

  always_ff @(posedge clk) begin
    page_r  <= page_nxt;
    frame_r <= frame_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= 1'b0;
    end else begin
      match_r <= match_nxt;
    end
  end

  assign page  = page_r;
  assign frame = frame_r;
  assign match = match_r;

endmodule

FILE: sv/lru_tlb_lookup_fill.sv
`timescale 1ns / 1ps

// Fully associative LRU translation buffer. A lookup is taken when start is
// high and busy is low; every lookup gives exactly one result, shown for one
// cycle on out_strobe, and the receiver cannot stall it. On the transfer
// edge every cell compares its page and registers the match; then busy is
// high during the update state, in which the chain shifts and loads and no
// new lookup is taken. The result appears on the cycle after that update,
// during which the next lookup can already be taken. Entry contents need no
// clearing after reset.
module lru_tlb_lookup_fill #(
  parameter int ENTRIES    = lrutlb_pkg::ENTRIES_DEF,
  parameter int PAGE_BITS  = lrutlb_pkg::PAGE_BITS_DEF,
  parameter int FRAME_BITS = lrutlb_pkg::FRAME_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [PAGE_BITS-1:0]      in_page,
  input  logic                      in_pt_valid,
  input  logic [FRAME_BITS-1:0]     in_pt_frame,
  output logic                      out_strobe,
  output lrutlb_pkg::status_t       out_status,
  output logic [FRAME_BITS-1:0]     out_frame
);

  localparam int CW = $clog2(ENTRIES + 1);
  localparam logic [CW-1:0] FULL = CW'(ENTRIES);

  typedef enum logic [1:0] {
    S_IDLE   = 2'b01,
    S_UPDATE = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [PAGE_BITS-1:0]  req_page_r;
  logic [FRAME_BITS-1:0] req_frame_r;
  logic                  req_valid_r;
  logic                  out_strobe_r, out_strobe_nxt;
  lrutlb_pkg::status_t   out_status_r, out_status_nxt;
  logic [FRAME_BITS-1:0] out_frame_r, out_frame_nxt;

  logic accept;
  logic in_update;
  logic [ENTRIES-1:0] match;
  logic [ENTRIES-1:0] below;
  logic hit;
  logic full;
  logic do_fill;
  logic [CW-1:0] tail;
  logic [PAGE_BITS-1:0]  hit_page;
  logic [FRAME_BITS-1:0] hit_frame;
  logic [PAGE_BITS-1:0]  ins_page;
  logic [FRAME_BITS-1:0] ins_frame;

  logic [PAGE_BITS-1:0]  cell_page  [ENTRIES];
  logic [FRAME_BITS-1:0] cell_frame [ENTRIES];
  logic [PAGE_BITS-1:0]  nbr_page   [ENTRIES];
  logic [FRAME_BITS-1:0] nbr_frame  [ENTRIES];
  lrutlb_pkg::cell_ctl_t ctl        [ENTRIES];

  assign accept    = start && !busy;
  assign in_update = (state_r == S_UPDATE);
  assign busy      = in_update;

  // Request capture
  always_ff @(posedge clk) begin
    if (accept) begin
      req_page_r  <= in_page;
      req_frame_r <= in_pt_frame;
      req_valid_r <= in_pt_valid;
    end
  end

  // Hit detection, hit position prefix and selected hit entry
  always_comb begin
    hit_page  = '0;
    hit_frame = '0;
    below[0]  = match[0];
    for (int i = 1; i < ENTRIES; i++) begin
      below[i] = below[i-1] | match[i];
    end
    for (int i = 0; i < ENTRIES; i++) begin
      if (match[i]) begin
        hit_page  = hit_page  | cell_page[i];
        hit_frame = hit_frame | cell_frame[i];
      end
    end
  end

  assign hit     = below[ENTRIES-1];
  assign full    = (count_r == FULL);
  assign do_fill = !hit && req_valid_r;

  // Slot that receives the insert data: MRU end on hit or full fill, else the append slot
  always_comb begin
    if (hit) begin
      tail = count_r - CW'(1);
    end else if (full) begin
      tail = FULL - CW'(1);
    end else begin
      tail = count_r;
    end
  end

  assign ins_page  = hit ? hit_page  : req_page_r;
  assign ins_frame = hit ? hit_frame : req_frame_r;

  // Cell controls
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      ctl[i].load  = in_update && (hit || do_fill) && (tail == CW'(i));
      ctl[i].shift = in_update &&
                     ((hit && below[i] && (CW'(i + 1) < count_r)) ||
                      (do_fill && full && (i < ENTRIES - 1)));
    end
  end

  // Chain of cells, each fed by its newer neighbor; the top one by the insert data
  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    if (g < ENTRIES - 1) begin : g_nbr
      assign nbr_page[g]  = cell_page[g+1];
      assign nbr_frame[g] = cell_frame[g+1];
    end else begin : g_top
      assign nbr_page[g]  = ins_page;
      assign nbr_frame[g] = ins_frame;
    end

    lrutlb_cell #(
      .PAGE_BITS  (PAGE_BITS),
      .FRAME_BITS (FRAME_BITS)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmp_en    (accept),
      .cmp_page  (in_page),
      .occupied  (CW'(g) < count_r),
      .ctl       (ctl[g]),
      .nbr_page  (nbr_page[g]),
      .nbr_frame (nbr_frame[g]),
      .ins_page  (ins_page),
      .ins_frame (ins_frame),
      .page      (cell_page[g]),
      .frame     (cell_frame[g]),
      .match     (match[g])
    );
  end

  // Sequencer, fill count and result
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    out_strobe_nxt = 1'b0;
    out_status_nxt = out_status_r;
    out_frame_nxt  = out_frame_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_UPDATE;
        end
      end
      S_UPDATE: begin
        state_nxt      = S_IDLE;
        out_strobe_nxt = 1'b1;
        if (hit) begin
          out_status_nxt = lrutlb_pkg::ST_HIT;
          out_frame_nxt  = hit_frame;
        end else if (req_valid_r) begin
          out_status_nxt = lrutlb_pkg::ST_FILL;
          out_frame_nxt  = req_frame_r;
          if (!full) begin
            count_nxt = count_r + CW'(1);
          end
        end else begin
          out_status_nxt = lrutlb_pkg::ST_FAULT;
          out_frame_nxt  = '0;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_frame_r  <= out_frame_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_status = out_status_r;
  assign out_frame  = out_frame_r;

  // Checks
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL)
    else $error("fill count above capacity");

  a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
    in_update |-> $countones(match) <= 1)
    else $error("duplicate page in buffer");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_update |=> out_strobe)
    else $error("update cycle without result");

  a_fault_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status == lrutlb_pkg::ST_FAULT) |-> out_frame == '0)
    else $error("fault result with nonzero frame");

endmodule

FILE: test/lru_tlb_lookup_fill_chk.sv
`timescale 1ns / 1ps

// Watches both sides of the translation buffer, keeps its own copy of the
// LRU-ordered entries and checks every result against the predicted one.
module lru_tlb_lookup_fill_chk #(
  parameter int ENTRIES    = lrutlb_pkg::ENTRIES_DEF,
  parameter int PAGE_BITS  = lrutlb_pkg::PAGE_BITS_DEF,
  parameter int FRAME_BITS = lrutlb_pkg::FRAME_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  busy,
  input  logic [PAGE_BITS-1:0]  in_page,
  input  logic                  in_pt_valid,
  input  logic [FRAME_BITS-1:0] in_pt_frame,
  input  logic                  out_strobe,
  input  lrutlb_pkg::status_t   out_status,
  input  logic [FRAME_BITS-1:0] out_frame,
  output int                    errors,
  output int                    outstanding
);

  typedef struct {
    lrutlb_pkg::status_t   status;
    logic [FRAME_BITS-1:0] frame;
  } xlate_t;

  // Shadow buffer: slot 0 is least recently used
  logic [PAGE_BITS-1:0]  shadow_page  [ENTRIES];
  logic [FRAME_BITS-1:0] shadow_frame [ENTRIES];
  int                    shadow_used;
  xlate_t                pending_xlates [$];

  assign outstanding = pending_xlates.size();

  // Look up one page, update the LRU order and return the translation
  function automatic xlate_t translate(logic [PAGE_BITS-1:0] page, logic valid,
                                       logic [FRAME_BITS-1:0] pfn);
    int                    pos;
    logic [PAGE_BITS-1:0]  hit_page;
    logic [FRAME_BITS-1:0] hit_frame;
    xlate_t                r;
    pos = -1;
    for (int i = 0; i < shadow_used; i++) begin
      if (pos < 0 && shadow_page[i] == page) pos = i;
    end
    if (pos >= 0) begin
      // hit: move to the most-recent end
      hit_page  = shadow_page[pos];
      hit_frame = shadow_frame[pos];
      for (int i = pos; i + 1 < shadow_used; i++) begin
        shadow_page[i]  = shadow_page[i + 1];
        shadow_frame[i] = shadow_frame[i + 1];
      end
      shadow_page[shadow_used - 1]  = hit_page;
      shadow_frame[shadow_used - 1] = hit_frame;
      r.status = lrutlb_pkg::ST_HIT;
      r.frame  = hit_frame;
    end else if (valid) begin
      // fill: append, or drop the oldest when full
      if (shadow_used < ENTRIES) begin
        shadow_page[shadow_used]  = page;
        shadow_frame[shadow_used] = pfn;
        shadow_used++;
      end else begin
        for (int i = 0; i + 1 < ENTRIES; i++) begin
          shadow_page[i]  = shadow_page[i + 1];
          shadow_frame[i] = shadow_frame[i + 1];
        end
        shadow_page[ENTRIES - 1]  = page;
        shadow_frame[ENTRIES - 1] = pfn;
      end
      r.status = lrutlb_pkg::ST_FILL;
      r.frame  = pfn;
    end else begin
      // fault: no state change
      r.status = lrutlb_pkg::ST_FAULT;
      r.frame  = '0;
    end
    return r;
  endfunction

  initial begin
    errors      = 0;
    shadow_used = 0;
  end

  // Compare the result transfer first, then queue the prediction for a new lookup
  always @(posedge clk) begin
    xlate_t want;
    if (!rst_n) begin
      shadow_used = 0;
      pending_xlates.delete();
    end else begin
      if (out_strobe) begin
        if (pending_xlates.size() == 0) begin
          $display("%0t: result with nothing pending: status %0d frame %02h",
                   $time, out_status, out_frame);
          errors++;
        end else begin
          want = pending_xlates.pop_front();
          if (out_status !== want.status || out_frame !== want.frame) begin
            $display("%0t: mismatch: expected status %0d frame %02h, got status %0d frame %02h",
                     $time, want.status, want.frame, out_status, out_frame);
            errors++;
          end
        end
      end
      if (start && !busy) begin
        pending_xlates.push_back(translate(in_page, in_pt_valid, in_pt_frame));
      end
    end
  end

endmodule

FILE: test/lru_tlb_lookup_fill_tb.sv
`timescale 1ns / 1ps

module lru_tlb_lookup_fill_tb;

  localparam int RANDOM_LOOKUPS = 830;
  localparam int DRAIN_AT       = 400;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic [7:0]          in_page;
  logic                in_pt_valid;
  logic [7:0]          in_pt_frame;
  logic                out_strobe;
  lrutlb_pkg::status_t out_status;
  logic [7:0]          out_frame;
  int                  errors;
  int                  outstanding;

  lru_tlb_lookup_fill dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_page     (in_page),
    .in_pt_valid (in_pt_valid),
    .in_pt_frame (in_pt_frame),
    .out_strobe  (out_strobe),
    .out_status  (out_status),
    .out_frame   (out_frame)
  );

  lru_tlb_lookup_fill_chk chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_page     (in_page),
    .in_pt_valid (in_pt_valid),
    .in_pt_frame (in_pt_frame),
    .out_strobe  (out_strobe),
    .out_status  (out_status),
    .out_frame   (out_frame),
    .errors      (errors),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // Mostly back-to-back, some short gaps, a few long ones
  function automatic int pick_gap(bit steady);
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Present one lookup and hold it until the transfer edge
  task automatic send_lookup(input logic [7:0] page, input logic valid,
                             input logic [7:0] pfn, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start       <= 1'b1;
    in_page     <= page;
    in_pt_valid <= valid;
    in_pt_frame <= pfn;
    do @(posedge clk); while (busy);
  endtask

  initial begin
    logic [7:0] base;
    int         span;
    bit         steady;
    logic [7:0] page;

    start       = 1'b0;
    in_page     = '0;
    in_pt_valid = 1'b0;
    in_pt_frame = '0;
    rst_n       = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty-buffer fault, extreme values, hits ignoring page-table fields
    send_lookup(8'h00, 1'b0, 8'h3c, 0);
    send_lookup(8'h00, 1'b1, 8'hff, pick_gap(0));
    send_lookup(8'hff, 1'b1, 8'h00, pick_gap(0));
    send_lookup(8'h00, 1'b0, 8'h55, pick_gap(0));
    send_lookup(8'hff, 1'b1, 8'haa, pick_gap(0));
    // fill up to capacity; page 00 is now the oldest
    for (int i = 1; i <= 14; i++) begin
      send_lookup(8'(i), 1'b1, 8'($urandom), pick_gap(0));
    end
    // full buffer: drops page 00
    send_lookup(8'h80, 1'b1, 8'h7e, pick_gap(0));
    send_lookup(8'h00, 1'b0, 8'h11, pick_gap(0));
    send_lookup(8'hff, 1'b0, 8'h22, pick_gap(0));
    send_lookup(8'h80, 1'b0, 8'h33, pick_gap(0));

    // Random: clustered pages around a moving base so hits and evictions mix
    base   = '0;
    span   = 16;
    steady = 1'b0;
    for (int n = 0; n < RANDOM_LOOKUPS; n++) begin
      if (n % 40 == 0) begin
        base   = 8'($urandom_range(0, 255));
        span   = $urandom_range(4, 30);
        steady = ($urandom_range(0, 3) == 0);
      end
      if (n == DRAIN_AT) begin
        // let every pending result come back before going on
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
      end
      if ($urandom_range(0, 99) < 8) page = 8'($urandom_range(0, 255));
      else page = base + 8'($urandom_range(0, span));
      send_lookup(page, ($urandom_range(0, 9) < 8), 8'($urandom),
                  (n == DRAIN_AT) ? 0 : pick_gap(steady));
    end
    start <= 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
